// ----- rtl/heading_pd_differential_thrust_defines.svh -----
// Assertion macros shared by the heading PD controller RTL.
`ifndef HEADING_PD_DIFFERENTIAL_THRUST_DEFINES_SVH
`define HEADING_PD_DIFFERENTIAL_THRUST_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define HPDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define HPDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hpdt_pkg.sv -----
// Types and constants for the heading PD controller.
package hpdt_pkg;

  // Field widths
  localparam int HEAD_W  = 12;
  localparam int PGAIN_W = 10;
  localparam int DGAIN_W = 10;
  localparam int PW_W    = 16;
  localparam int ERR_W   = 12;
  localparam int DIFF_W  = 13;
  localparam int PPROD_W = 23;
  localparam int DPROD_W = 24;
  localparam int PMAG_W  = 21;
  localparam int DIVM_W  = 21;
  localparam int PQ_W    = 18;
  localparam int P_W     = 19;
  localparam int SUM_W   = 25;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CTR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CTR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING    = 3'd6;

  // Reset values
  localparam logic [PW_W-1:0] RST_CENTER  = 16'd2779;
  localparam logic [PW_W-1:0] RST_FLOOR   = 16'd2031;
  localparam logic [PW_W-1:0] RST_CEILING = 16'd3508;

  // Angle wrap, tenths of a degree
  localparam logic signed [DIFF_W-1:0] WRAP_HALF = 13'sd1800;
  localparam logic signed [DIFF_W-1:0] WRAP_FULL = 13'sd3600;

  // x/10 = (x * ceil(2^24/10)) >> 24, exact for x < 2^22
  localparam logic [DIVM_W-1:0] DIV10_MUL   = 21'd1677722;
  localparam int                DIV10_SHIFT = 24;

  typedef struct packed {
    logic [HEAD_W-1:0]  target;
    logic [PGAIN_W-1:0] prop_gain;
    logic [DGAIN_W-1:0] deriv_gain;
    logic [PW_W-1:0]    left_ctr;
    logic [PW_W-1:0]    right_ctr;
    logic [PW_W-1:0]    floor_w;
    logic [PW_W-1:0]    ceil_w;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [PPROD_W-1:0] pprod;
    logic signed [DPROD_W-1:0] dprod;
  } err_word_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [P_W-1:0]     p_term;
    logic signed [DPROD_W-1:0] d_term;
  } term_word_t;

endpackage

// ----- rtl/heading_pd_differential_thrust.sv -----
// Heading PD controller with differential fan thrust, top level.
// Each input word carries one compass heading in tenths of a degree. The
// block forms the heading error (target minus heading, wrapped once into
// -1800..1800), a P term of prop_gain_tenths * error / 10 truncated toward
// zero, and a D term of deriv_gain times the change in error since the
// previous word. Right width = right center + P + D, left width = left
// center - P - D; left is limited to the ceiling and then raised to the
// floor, right is raised to the floor and then limited to the ceiling.
// One result word leaves for every input word, in order. Throughput is one
// word per clock: a new word is taken every cycle as long as the result
// side keeps up. On its way to out_valid each word passes four register
// ranks: input, gain products, divide by ten (reciprocal multiply), and the
// result register. Write configuration only while no word is in flight;
// out-of-range register indexes are ignored.
module heading_pd_differential_thrust
  import hpdt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [PW_W-1:0]         cfg_data,
  // heading input word
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [HEAD_W-1:0]       in_compass_heading,
  // result word
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PW_W-1:0]         out_left_width,
  output logic [PW_W-1:0]         out_right_width,
  output logic signed [ERR_W-1:0] out_wrapped_error
);

  cfg_t       cfg_r;
  logic       e2d_valid, e2d_ready;
  err_word_t  e2d_word;
  logic       d2o_valid, d2o_ready;
  term_word_t d2o_word;

  // configuration registers, reset to their documented values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target     <= '0;
      cfg_r.prop_gain  <= '0;
      cfg_r.deriv_gain <= '0;
      cfg_r.left_ctr   <= RST_CENTER;
      cfg_r.right_ctr  <= RST_CENTER;
      cfg_r.floor_w    <= RST_FLOOR;
      cfg_r.ceil_w     <= RST_CEILING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET:     cfg_r.target     <= cfg_data[HEAD_W-1:0];
        CFG_PROP_GAIN:  cfg_r.prop_gain  <= cfg_data[PGAIN_W-1:0];
        CFG_DERIV_GAIN: cfg_r.deriv_gain <= cfg_data[DGAIN_W-1:0];
        CFG_LEFT_CTR:   cfg_r.left_ctr   <= cfg_data;
        CFG_RIGHT_CTR:  cfg_r.right_ctr  <= cfg_data;
        CFG_FLOOR:      cfg_r.floor_w    <= cfg_data;
        CFG_CEILING:    cfg_r.ceil_w     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, error wrap, P and D products; holds the previous error
  hpdt_err_stage u_err (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_heading (in_compass_heading),
    .dn_valid   (e2d_valid),
    .dn_ready   (e2d_ready),
    .dn_word    (e2d_word)
  );

  // P product divided by ten via reciprocal multiply
  hpdt_div_stage u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (e2d_valid),
    .up_ready (e2d_ready),
    .up_word  (e2d_word),
    .dn_valid (d2o_valid),
    .dn_ready (d2o_ready),
    .dn_word  (d2o_word)
  );

  // mixing, saturation and result register
  hpdt_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (d2o_valid),
    .up_ready  (d2o_ready),
    .up_word   (d2o_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left_width),
    .out_right (out_right_width),
    .out_err   (out_wrapped_error)
  );

endmodule

// ----- rtl/hpdt_err_stage.sv -----
// Input register, heading error wrap and gain products.
`include "heading_pd_differential_thrust_defines.svh"

module hpdt_err_stage
  import hpdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HEAD_W-1:0] in_heading,
  output logic              dn_valid,
  input  logic              dn_ready,
  output err_word_t         dn_word
);

  logic                     s0_vld_r, s0_vld_nxt;
  logic [HEAD_W-1:0]        s0_head_r;
  logic                     s1_vld_r, s1_vld_nxt;
  err_word_t                s1_r, s1_nxt;
  logic signed [ERR_W-1:0]  last_err_r;
  logic                     s1_free, s0_go, in_take;
  logic signed [DIFF_W-1:0] diff, wrapped, delta;
  logic signed [ERR_W-1:0]  err;

  assign s1_free  = !s1_vld_r || dn_ready;
  assign s0_go    = s0_vld_r && s1_free;
  assign in_ready = !s0_vld_r || s1_free;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s0_vld_nxt = s0_vld_r;
    if (in_take) begin
      s0_vld_nxt = 1'b1;
    end else if (s0_go) begin
      s0_vld_nxt = 1'b0;
    end
    s1_vld_nxt = s1_vld_r;
    if (s0_go) begin
      s1_vld_nxt = 1'b1;
    end else if (dn_ready) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // single wrap into -1800..1800
  always_comb begin
    diff = $signed({1'b0, cfg.target}) - $signed({1'b0, s0_head_r});
    if (diff > WRAP_HALF) begin
      wrapped = diff - WRAP_FULL;
    end else if (diff < -WRAP_HALF) begin
      wrapped = diff + WRAP_FULL;
    end else begin
      wrapped = diff;
    end
    err   = wrapped[ERR_W-1:0];
    delta = $signed({err[ERR_W-1], err}) - $signed({last_err_r[ERR_W-1], last_err_r});
    s1_nxt.err   = err;
    s1_nxt.pprod = $signed({1'b0, cfg.prop_gain}) * err;
    s1_nxt.dprod = $signed({1'b0, cfg.deriv_gain}) * delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r   <= 1'b0;
      s1_vld_r   <= 1'b0;
      last_err_r <= '0;
    end else begin
      s0_vld_r <= s0_vld_nxt;
      s1_vld_r <= s1_vld_nxt;
      if (s0_go) begin
        last_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_head_r <= in_heading;
    end
    if (s0_go) begin
      s1_r <= s1_nxt;
    end
  end

  assign dn_valid = s1_vld_r;
  assign dn_word  = s1_r;

  `HPDT_ASSERT_NOW(a_err_range, s1_vld_r, (s1_r.err <= 12'sd1800) && (s1_r.err >= -12'sd1800), "wrapped error out of range")
  `HPDT_ASSERT_NEXT(a_last_err_track, s0_go, last_err_r == s1_r.err, "previous error not tracking stage word")

endmodule

// ----- rtl/hpdt_div_stage.sv -----
// Proportional term divide by ten, truncating toward zero.
`include "heading_pd_differential_thrust_defines.svh"

module hpdt_div_stage
  import hpdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  err_word_t  up_word,
  output logic       dn_valid,
  input  logic       dn_ready,
  output term_word_t dn_word
);

  logic                      vld_r, vld_nxt;
  term_word_t                word_r, word_nxt;
  logic                      go, neg;
  logic signed [PPROD_W-1:0] pabs;
  logic [PMAG_W-1:0]         pmag;
  logic [PMAG_W+DIVM_W-1:0]  prod;
  logic [PQ_W-1:0]           quo;

  assign up_ready = !vld_r || dn_ready;
  assign go       = up_valid && up_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (go) begin
      vld_nxt = 1'b1;
    end else if (dn_ready) begin
      vld_nxt = 1'b0;
    end
  end

  // magnitude through reciprocal, sign put back afterwards
  always_comb begin
    neg  = up_word.pprod[PPROD_W-1];
    pabs = neg ? -up_word.pprod : up_word.pprod;
    pmag = pabs[PMAG_W-1:0];
    prod = pmag * DIV10_MUL;
    quo  = prod[DIV10_SHIFT +: PQ_W];
    word_nxt.err    = up_word.err;
    word_nxt.p_term = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    word_nxt.d_term = up_word.dprod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_word  = word_r;

  `HPDT_ASSERT_NEXT(a_p_sign, go, (word_r.p_term == '0) || (word_r.p_term[P_W-1] == $past(up_word.pprod[PPROD_W-1])), "P term sign flipped")

endmodule

// ----- rtl/hpdt_out_stage.sv -----
// Center plus terms, saturation and the result register.
module hpdt_out_stage
  import hpdt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  term_word_t              up_word,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PW_W-1:0]         out_left,
  output logic [PW_W-1:0]         out_right,
  output logic signed [ERR_W-1:0] out_err
);

  logic                     vld_r, vld_nxt, go;
  logic [PW_W-1:0]          left_r, left_nxt, right_r, right_nxt;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  p_ext, d_ext, lc, rc, lo, hi;
  logic signed [SUM_W-1:0]  left_sum, right_sum, left_t, right_t, left_c, right_c;

  assign up_ready = !vld_r || out_ready;
  assign go       = up_valid && up_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (go) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_comb begin
    p_ext = $signed({{(SUM_W-P_W){up_word.p_term[P_W-1]}}, up_word.p_term});
    d_ext = $signed({{(SUM_W-DPROD_W){up_word.d_term[DPROD_W-1]}}, up_word.d_term});
    lc    = $signed({{(SUM_W-PW_W){1'b0}}, cfg.left_ctr});
    rc    = $signed({{(SUM_W-PW_W){1'b0}}, cfg.right_ctr});
    lo    = $signed({{(SUM_W-PW_W){1'b0}}, cfg.floor_w});
    hi    = $signed({{(SUM_W-PW_W){1'b0}}, cfg.ceil_w});
    right_sum = rc + p_ext + d_ext;
    left_sum  = lc - p_ext - d_ext;
    // left: ceiling first, then floor; right: floor first, then ceiling
    left_t    = (left_sum > hi) ? hi : left_sum;
    left_c    = (left_t < lo) ? lo : left_t;
    right_t   = (right_sum < lo) ? lo : right_sum;
    right_c   = (right_t > hi) ? hi : right_t;
    left_nxt  = left_c[PW_W-1:0];
    right_nxt = right_c[PW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      err_r   <= up_word.err;
    end
  end

  assign out_valid = vld_r;
  assign out_left  = left_r;
  assign out_right = right_r;
  assign out_err   = err_r;

endmodule

// ----- dv/heading_pd_differential_thrust_tb.sv -----
// Self-checking testbench for the heading PD differential thrust controller.
module heading_pd_differential_thrust_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpdt_pkg::*;

  // Index 7 is decoded by nobody; a write to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Random part: eight settings of the registers, the last one run without idling.
  localparam int SETTING_COUNT   = 8;
  localparam int WORDS_PER_SETTING = 167;

  typedef enum logic { STEP_WORD, STEP_CFG } step_kind_e;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [PW_W-1:0]         left;
    logic [PW_W-1:0]         right;
    logic signed [ERR_W-1:0] err;
  } thrust_t;

  // One row of the directed table: a heading word or a register write. A word
  // row with typed set carries its result, read straight off the spec.
  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [PW_W-1:0]      data;
    logic                 typed;
    thrust_t              want;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [PW_W-1:0]         cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [HEAD_W-1:0]       in_compass_heading = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PW_W-1:0]         out_left_width;
  logic [PW_W-1:0]         out_right_width;
  logic signed [ERR_W-1:0] out_wrapped_error;

  // Shadow of the register file and of the stored error, kept in step with the DUT.
  cfg_t                    regs_shadow;
  logic signed [ERR_W-1:0] prev_err;

  thrust_t   thrust_q[$];   // results still owed by the DUT, oldest first
  plan_row_t plan_q[$];     // directed table
  thrust_t   got_want;
  int        mismatch_count = 0;
  bit        steady = 1'b0; // set for the last stretch: no gaps, no stalls
  bit        idle_on = 1'b1;

  heading_pd_differential_thrust u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_compass_heading (in_compass_heading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_left_width     (out_left_width),
    .out_right_width    (out_right_width),
    .out_wrapped_error  (out_wrapped_error)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop: far beyond the slowest legal run, in which every word waits out a
  // full sender gap and a full receiver stall.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: %s", $time, what);
  endtask

  // Predicted result for one heading word; also advances the stored error.
  function automatic thrust_t compute_thrust(input logic [HEAD_W-1:0] heading);
    int      err_i;
    longint  p_term, d_term, left_w, right_w, lo, hi;
    thrust_t res;
    err_i = int'(regs_shadow.target) - int'(heading);
    // one wrap only; 12-bit inputs above 3599 still land in range
    if (err_i > int'(WRAP_HALF)) err_i -= int'(WRAP_FULL);
    else if (err_i < -int'(WRAP_HALF)) err_i += int'(WRAP_FULL);
    // P gain is in tenths; signed divide truncates toward zero
    p_term  = (longint'(regs_shadow.prop_gain) * err_i) / 10;
    d_term  = longint'(regs_shadow.deriv_gain) * (err_i - int'(prev_err));
    right_w = longint'(regs_shadow.right_ctr) + p_term + d_term;
    left_w  = longint'(regs_shadow.left_ctr) - p_term - d_term;
    lo = longint'(regs_shadow.floor_w);
    hi = longint'(regs_shadow.ceil_w);
    // left: ceiling first, then floor; right: floor first, then ceiling.
    // With floor above ceiling this leaves left at floor, right at ceiling.
    if (left_w > hi) left_w = hi;
    if (left_w < lo) left_w = lo;
    if (right_w < lo) right_w = lo;
    if (right_w > hi) right_w = hi;
    res.left  = left_w[PW_W-1:0];
    res.right = right_w[PW_W-1:0];
    res.err   = err_i[ERR_W-1:0];
    prev_err  = err_i[ERR_W-1:0];
    return res;
  endfunction

  // Gains: mostly small so widths stay off the limits, sometimes the extremes
  // and the codes above 999 that the 10-bit field still allows.
  function automatic logic [PW_W-1:0] pick_gain();
    logic [PW_W-1:0] g;
    g = 16'($urandom);
    case ($urandom_range(0, 5))
      0: g[DGAIN_W-1:0] = '0;
      1: g[DGAIN_W-1:0] = 10'd999;
      2: g[DGAIN_W-1:0] = 10'($urandom_range(1000, 1023));
      default: g[DGAIN_W-1:0] = 10'($urandom_range(0, 40));
    endcase
    return g;
  endfunction

  // Register write: a one-cycle strobe on the enable, then the enable held down.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PW_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_TARGET:     regs_shadow.target     = data[HEAD_W-1:0];
      CFG_PROP_GAIN:  regs_shadow.prop_gain  = data[PGAIN_W-1:0];
      CFG_DERIV_GAIN: regs_shadow.deriv_gain = data[DGAIN_W-1:0];
      CFG_LEFT_CTR:   regs_shadow.left_ctr   = data;
      CFG_RIGHT_CTR:  regs_shadow.right_ctr  = data;
      CFG_FLOOR:      regs_shadow.floor_w    = data;
      CFG_CEILING:    regs_shadow.ceil_w     = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender goes quiet until every owed result is out, plus the pipe depth.
  task automatic drain_words();
    in_valid <= 1'b0;
    while (thrust_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one heading word, optionally after a gap, and log its result once taken.
  task automatic send_heading(input logic [HEAD_W-1:0] heading, input logic typed,
                              input thrust_t typed_want);
    thrust_t pred;
    int      gap;
    gap = 0;
    if (idle_on && !steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_compass_heading <= heading;
    do @(posedge clk); while (!in_ready);
    pred = compute_thrust(heading);
    thrust_q.push_back(typed ? typed_want : pred);
  endtask

  task automatic plan_word(input logic [HEAD_W-1:0] heading, input logic typed,
                           input logic [PW_W-1:0] left_w, input logic [PW_W-1:0] right_w,
                           input logic signed [ERR_W-1:0] err_w);
    plan_row_t row;
    row.kind       = STEP_WORD;
    row.idx        = CFG_TARGET;
    row.data       = {{(PW_W-HEAD_W){1'b0}}, heading};
    row.typed      = typed;
    row.want.left  = left_w;
    row.want.right = right_w;
    row.want.err   = err_w;
    plan_q.push_back(row);
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [PW_W-1:0] data);
    plan_row_t row;
    row.kind  = STEP_CFG;
    row.idx   = idx;
    row.data  = data;
    row.typed = 1'b0;
    row.want  = '0;
    plan_q.push_back(row);
  endtask

  // Receiver: ready bursts broken by stalls, always ready at the end.
  initial begin
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Result checker: every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (thrust_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        got_want = thrust_q.pop_front();
        if (out_left_width !== got_want.left)
          report_mismatch($sformatf("left width %0d, want %0d",
                                    out_left_width, got_want.left));
        if (out_right_width !== got_want.right)
          report_mismatch($sformatf("right width %0d, want %0d",
                                    out_right_width, got_want.right));
        if (out_wrapped_error !== got_want.err)
          report_mismatch($sformatf("wrapped error %0d, want %0d",
                                    out_wrapped_error, got_want.err));
      end
    end
  end

  // Main stimulus
  initial begin
    int               h_walk;
    int               pick;
    int               lo_i, hi_i;
    logic [HEAD_W-1:0] heading;
    logic [PW_W-1:0]  v;

    regs_shadow.target     = '0;
    regs_shadow.prop_gain  = '0;
    regs_shadow.deriv_gain = '0;
    regs_shadow.left_ctr   = RST_CENTER;
    regs_shadow.right_ctr  = RST_CENTER;
    regs_shadow.floor_w    = RST_FLOOR;
    regs_shadow.ceil_w     = RST_CEILING;
    prev_err               = '0;
    h_walk                 = 0;

    // Reset values: zero gains, so both widths sit at the 2779 center and only
    // the wrap shows. Covers the wrap edges and all-zero / all-one headings.
    plan_word(12'd0,    1'b1, 16'd2779, 16'd2779, 12'sd0);
    plan_word(12'd1800, 1'b1, 16'd2779, 16'd2779, -12'sd1800); // edge, no wrap
    plan_word(12'd1801, 1'b1, 16'd2779, 16'd2779, 12'sd1799);  // just past, wraps
    plan_word(12'd3599, 1'b1, 16'd2779, 16'd2779, 12'sd1);
    plan_word(12'd4095, 1'b1, 16'd2779, 16'd2779, -12'sd495);  // heading above 3599
    plan_word(12'd2048, 1'b1, 16'd2779, 16'd2779, 12'sd1552);
    // Everything at the top: target above 3599, widest width range, big gains.
    plan_cfg(CFG_TARGET,     16'hFFFF);
    plan_cfg(CFG_PROP_GAIN,  16'd999);
    plan_cfg(CFG_DERIV_GAIN, 16'd999);
    plan_cfg(CFG_LEFT_CTR,   16'd0);
    plan_cfg(CFG_RIGHT_CTR,  16'hFFFF);
    plan_cfg(CFG_FLOOR,      16'd0);
    plan_cfg(CFG_CEILING,    16'hFFFF);
    plan_cfg(CFG_UNUSED,     16'h5A5A);                          // must be dropped
    plan_word(12'd0,    1'b0, '0, '0, '0);
    plan_word(12'd2295, 1'b0, '0, '0, '0);
    plan_word(12'd4095, 1'b0, '0, '0, '0);
    plan_word(12'd1,    1'b0, '0, '0, '0);
    // Small P gain, no D: truncation toward zero on negative products.
    plan_cfg(CFG_TARGET,     16'd0);
    plan_cfg(CFG_PROP_GAIN,  16'd5);
    plan_cfg(CFG_DERIV_GAIN, 16'd0);
    plan_cfg(CFG_LEFT_CTR,   RST_CENTER);
    plan_cfg(CFG_RIGHT_CTR,  RST_CENTER);
    plan_cfg(CFG_FLOOR,      RST_FLOOR);
    plan_cfg(CFG_CEILING,    RST_CEILING);
    plan_word(12'd1,    1'b0, '0, '0, '0);
    plan_word(12'd3599, 1'b0, '0, '0, '0);
    plan_word(12'd3,    1'b0, '0, '0, '0);
    plan_word(12'd1797, 1'b0, '0, '0, '0);
    // Floor above ceiling with zero gains: left pinned at floor, right at ceiling.
    plan_cfg(CFG_PROP_GAIN,  16'd0);
    plan_cfg(CFG_FLOOR,      16'd3000);
    plan_cfg(CFG_CEILING,    16'd2000);
    plan_word(12'd100,  1'b1, 16'd3000, 16'd2000, -12'sd100);
    plan_word(12'd3500, 1'b1, 16'd3000, 16'd2000, 12'sd100);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register rows wait for the pipe to empty first.
    foreach (plan_q[i]) begin
      if (plan_q[i].kind == STEP_CFG) begin
        drain_words();
        write_reg(plan_q[i].idx, plan_q[i].data);
      end else begin
        send_heading(plan_q[i].data[HEAD_W-1:0], plan_q[i].typed, plan_q[i].want);
      end
    end

    // Random part: a fresh register setting per stretch, headings mostly a slow
    // drift (as a real compass gives, so the D term stays meaningful), the rest
    // jumps across the full 12-bit field and hits right around the wrap point.
    for (int setting = 0; setting < SETTING_COUNT; setting++) begin
      drain_words();
      steady  = (setting == SETTING_COUNT - 1);
      idle_on = !steady && ($urandom_range(0, 3) != 0);

      v = 16'($urandom);
      v[HEAD_W-1:0] = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(0, 3599))
                                                 : 12'($urandom_range(3600, 4095));
      write_reg(CFG_TARGET, v);
      write_reg(CFG_PROP_GAIN, pick_gain());
      write_reg(CFG_DERIV_GAIN, pick_gain());
      v = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 3600));
      write_reg(CFG_LEFT_CTR, v);
      v = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 3600));
      write_reg(CFG_RIGHT_CTR, v);
      case ($urandom_range(0, 4))
        0: begin
          lo_i = 0;
          hi_i = 65535;
        end
        1: begin   // floor at or above ceiling
          lo_i = $urandom_range(2500, 4000);
          hi_i = $urandom_range(1500, lo_i);
        end
        2: begin
          lo_i = $urandom_range(0, 65535);
          hi_i = $urandom_range(0, 65535);
        end
        default: begin
          lo_i = $urandom_range(1500, 2700);
          hi_i = $urandom_range(2800, 4000);
        end
      endcase
      write_reg(CFG_FLOOR, lo_i[PW_W-1:0]);
      write_reg(CFG_CEILING, hi_i[PW_W-1:0]);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 16'($urandom));

      repeat (WORDS_PER_SETTING) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          h_walk  = (h_walk + $urandom_range(0, 120) + 3540) % 3600;
          heading = h_walk[HEAD_W-1:0];
        end else if (pick < 8) begin
          heading = 12'($urandom_range(0, 4095));
        end else begin
          h_walk  = (int'(regs_shadow.target) + $urandom_range(1750, 1850)) % 4096;
          heading = h_walk[HEAD_W-1:0];
          h_walk  = h_walk % 3600;
        end
        // now and then hold off until every owed result has come back
        if (!steady && $urandom_range(0, 149) == 0) drain_words();
        send_heading(heading, 1'b0, '0);
      end
    end

    drain_words();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- heading_pd_differential_thrust.f -----
+incdir+rtl
rtl/hpdt_pkg.sv
rtl/hpdt_err_stage.sv
rtl/hpdt_div_stage.sv
rtl/hpdt_out_stage.sv
rtl/heading_pd_differential_thrust.sv
dv/heading_pd_differential_thrust_tb.sv
